### hdl/thd_pkg.sv
// package: shared types, mnemonic codes and queue sizing for the thumb decoder
`timescale 1ns / 1ps

package thd_pkg;

	// decoupling queue between front and back (depth is a power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// mnemonic codes, dense in decode order
	localparam logic [5:0] MN_NONE      = 6'd0;
	localparam logic [5:0] MN_ADDS_REG  = 6'd1;
	localparam logic [5:0] MN_LSLS_IMM  = 6'd5;
	localparam logic [5:0] MN_MOVS_IMM8 = 6'd8;
	localparam logic [5:0] MN_ALU_ANDS  = 6'd12;
	localparam logic [5:0] MN_BX        = 6'd28;
	localparam logic [5:0] MN_LDR_LIT   = 6'd29;
	localparam logic [5:0] MN_STRH_REG  = 6'd30;
	localparam logic [5:0] MN_STR_REG   = 6'd34;
	localparam logic [5:0] MN_STR_IMM   = 6'd38;
	localparam logic [5:0] MN_STR_SP    = 6'd42;
	localparam logic [5:0] MN_STRH_IMM  = 6'd44;
	localparam logic [5:0] MN_PUSH      = 6'd46;
	localparam logic [5:0] MN_SP_ADJ    = 6'd48;
	localparam logic [5:0] MN_SWI       = 6'd49;
	localparam logic [5:0] MN_B_COND    = 6'd50;
	localparam logic [5:0] MN_B         = 6'd51;
	localparam logic [5:0] MN_BL        = 6'd52;

	localparam logic [3:0] COND_AL  = 4'd14;
	localparam logic [3:0] COND_SWI = 4'd15;
	localparam logic [3:0] REG_SP   = 4'd13;
	localparam logic [3:0] REG_PC   = 4'd15;

	// one classified item travelling from front to back
	typedef struct packed {
		logic [15:0] hw;
		logic [31:0] item_addr;
		logic [31:0] item_addr4;
		logic        is_bl;
		logic [31:0] bl_off;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

### hdl/thd_front.sv
// front: takes halfwords, tracks the address and pairs up the two halves of a bl
`timescale 1ns / 1ps

module thd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        halfword_in,
	input  thd_pkg::q_status_t q_status,
	output thd_pkg::q_push_t   q_push
);

	logic [31:0] cur_q;
	logic        bl_pend_q;
	logic [10:0] bl_half_q;
	logic        bl_h_q;
	logic [31:0] bl_addr_q;

	logic        accept;
	logic        is_bl_first;
	logic [31:0] item_addr;
	logic [23:0] off_a;
	logic [23:0] off_b;
	logic [23:0] off_sum;
	logic [31:0] bl_off;

	assign in_stall    = q_status.full;
	assign accept      = in_valid && !q_status.full;
	assign is_bl_first = !bl_pend_q && (halfword_in[15:12] == 4'b1111);
	assign item_addr   = bl_pend_q ? bl_addr_q : cur_q;

	// combined bl offset, sign taken from bit 22
	always_comb begin
		off_a   = bl_h_q ? {12'd0, bl_half_q, 1'b0} : {1'b0, bl_half_q, 12'd0};
		off_b   = halfword_in[11] ? {12'd0, halfword_in[10:0], 1'b0}
		                          : {1'b0, halfword_in[10:0], 12'd0};
		off_sum = off_a + off_b;
		bl_off  = off_sum[22] ? {9'h1FF, off_sum[22:0]} : {8'd0, off_sum};
	end

	always_comb begin
		q_push.valid            = accept && !is_bl_first;
		q_push.entry.hw         = halfword_in;
		q_push.entry.item_addr  = item_addr;
		q_push.entry.item_addr4 = item_addr + 32'd4;
		q_push.entry.is_bl      = bl_pend_q;
		q_push.entry.bl_off     = bl_off;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			bl_pend_q <= 1'b0;
			bl_half_q <= '0;
			bl_h_q    <= 1'b0;
			bl_addr_q <= '0;
		end else if (cfg_wr_en) begin
			cur_q     <= cfg_wr_data;
			bl_pend_q <= 1'b0;
			bl_half_q <= '0;
			bl_h_q    <= 1'b0;
		end else if (accept) begin
			cur_q <= cur_q + 32'd2;
			if (bl_pend_q) begin
				bl_pend_q <= 1'b0;
				bl_half_q <= '0;
				bl_h_q    <= 1'b0;
			end else if (is_bl_first) begin
				bl_pend_q <= 1'b1;
				bl_half_q <= halfword_in[10:0];
				bl_h_q    <= halfword_in[11];
				bl_addr_q <= cur_q;
			end
		end
	end

endmodule

### hdl/thd_queue.sv
// queue: small register fifo between the front and the back
`timescale 1ns / 1ps

module thd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  thd_pkg::q_push_t   q_push,
	input  logic               pop,
	output thd_pkg::q_status_t q_status,
	output thd_pkg::q_entry_t  head
);

	thd_pkg::q_entry_t             mem_q [thd_pkg::QUEUE_DEPTH];
	logic [thd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [thd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [thd_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == thd_pkg::QCNT_W'(thd_pkg::QUEUE_DEPTH));
	assign do_push        = q_push.valid && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/thd_back.sv
// back: decodes the queue head into result fields and holds them in the output register
`timescale 1ns / 1ps

module thd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  thd_pkg::q_status_t q_status,
	input  thd_pkg::q_entry_t  head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         mnemonic,
	output logic               recognized,
	output logic [3:0]         branch_cond,
	output logic [3:0]         reg_dest,
	output logic [3:0]         reg_base,
	output logic [2:0]         reg_offset,
	output logic [9:0]         imm_value,
	output logic               sp_subtract,
	output logic [31:0]        target_address,
	output logic [8:0]         reg_list,
	output logic [31:0]        item_address
);

	logic        out_valid_q;
	logic [5:0]  mn_q;
	logic [3:0]  cond_q;
	logic [3:0]  rd_q;
	logic [3:0]  rb_q;
	logic [2:0]  ro_q;
	logic [9:0]  imm_q;
	logic        sub_q;
	logic [31:0] tgt_q;
	logic [8:0]  list_q;
	logic [31:0] item_q;

	logic [15:0] h;
	logic [5:0]  mn;
	logic [3:0]  cond;
	logic [3:0]  rd;
	logic [3:0]  rb;
	logic [2:0]  ro;
	logic [9:0]  imm;
	logic        sub;
	logic [8:0]  list;
	logic        has_tgt;
	logic [31:0] tgt_base;
	logic [31:0] tgt_off;
	logic [31:0] tgt;

	assign h   = head.hw;
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	always_comb begin
		mn       = thd_pkg::MN_NONE;
		cond     = thd_pkg::COND_AL;
		rd       = '0;
		rb       = '0;
		ro       = '0;
		imm      = '0;
		sub      = 1'b0;
		list     = '0;
		has_tgt  = 1'b0;
		tgt_base = head.item_addr4;
		tgt_off  = '0;
		if (head.is_bl) begin
			mn      = thd_pkg::MN_BL;
			has_tgt = 1'b1;
			tgt_off = head.bl_off;
		end else begin
			case (h[15:13])
				3'd0: begin
					rd = {1'b0, h[2:0]};
					rb = {1'b0, h[5:3]};
					if (h[12:11] == 2'b11) begin
						mn = thd_pkg::MN_ADDS_REG + {4'd0, h[9], h[10]};
						if (h[10]) begin
							imm = {7'd0, h[8:6]};
						end else begin
							ro = h[8:6];
						end
					end else begin
						mn  = thd_pkg::MN_LSLS_IMM + {4'd0, h[12:11]};
						imm = {5'd0, h[10:6]};
					end
				end
				3'd1: begin
					mn  = thd_pkg::MN_MOVS_IMM8 + {4'd0, h[12:11]};
					rd  = {1'b0, h[10:8]};
					imm = {2'd0, h[7:0]};
				end
				3'd2: begin
					if (h[12:10] == 3'b000) begin
						mn = thd_pkg::MN_ALU_ANDS + {2'd0, h[9:6]};
						rd = {1'b0, h[2:0]};
						rb = {1'b0, h[5:3]};
					end else if (h[12:10] == 3'b001) begin
						if (h[9:8] == 2'b11) begin
							mn = thd_pkg::MN_BX;
							rb = h[6:3];
						end
					end else if (h[12:11] == 2'b01) begin
						// pc-relative literal, base is the word-aligned pc
						mn       = thd_pkg::MN_LDR_LIT;
						rd       = {1'b0, h[10:8]};
						rb       = thd_pkg::REG_PC;
						imm      = {h[7:0], 2'b00};
						has_tgt  = 1'b1;
						tgt_base = {head.item_addr4[31:2], 2'b00};
						tgt_off  = {22'd0, h[7:0], 2'b00};
					end else begin
						rd = {1'b0, h[2:0]};
						rb = {1'b0, h[5:3]};
						ro = h[8:6];
						if (h[9]) begin
							mn = thd_pkg::MN_STRH_REG + {4'd0, h[11:10]};
						end else begin
							mn = thd_pkg::MN_STR_REG + {4'd0, h[11], h[10]};
						end
					end
				end
				3'd3: begin
					mn  = thd_pkg::MN_STR_IMM + {4'd0, h[11], h[12]};
					rd  = {1'b0, h[2:0]};
					rb  = {1'b0, h[5:3]};
					imm = h[12] ? {5'd0, h[10:6]} : {3'd0, h[10:6], 2'b00};
				end
				3'd4: begin
					if (h[12]) begin
						mn  = thd_pkg::MN_STR_SP + {5'd0, h[11]};
						rd  = {1'b0, h[10:8]};
						rb  = thd_pkg::REG_SP;
						imm = {h[7:0], 2'b00};
					end else begin
						mn  = thd_pkg::MN_STRH_IMM + {5'd0, h[11]};
						rd  = {1'b0, h[2:0]};
						rb  = {1'b0, h[5:3]};
						imm = {4'd0, h[10:6], 1'b0};
					end
				end
				3'd5: begin
					if (h[12]) begin
						if (h[10]) begin
							mn   = thd_pkg::MN_PUSH + {5'd0, h[11]};
							rb   = thd_pkg::REG_SP;
							list = h[8:0];
						end else begin
							mn  = thd_pkg::MN_SP_ADJ;
							rd  = thd_pkg::REG_SP;
							rb  = thd_pkg::REG_SP;
							imm = {1'b0, h[6:0], 2'b00};
							sub = h[7];
						end
					end
				end
				3'd6: begin
					if (h[12]) begin
						if (h[11:8] == thd_pkg::COND_SWI) begin
							mn  = thd_pkg::MN_SWI;
							imm = {2'd0, h[7:0]};
						end else begin
							mn      = thd_pkg::MN_B_COND;
							cond    = h[11:8];
							has_tgt = 1'b1;
							tgt_off = {{23{h[7]}}, h[7:0], 1'b0};
						end
					end
				end
				default: begin
					// first bl halves never reach the back
					if (!h[12]) begin
						mn      = thd_pkg::MN_B;
						has_tgt = 1'b1;
						tgt_off = {{20{h[10]}}, h[10:0], 1'b0};
					end
				end
			endcase
		end
		tgt = has_tgt ? (tgt_base + tgt_off) : '0;
		// unrecognized formats show every decoded field at its idle value; the item address still passes
		if (mn == thd_pkg::MN_NONE) begin
			cond = thd_pkg::COND_AL;
			rd   = '0;
			rb   = '0;
			ro   = '0;
			imm  = '0;
			sub  = 1'b0;
			list = '0;
			tgt  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mn_q   <= mn;
			cond_q <= cond;
			rd_q   <= rd;
			rb_q   <= rb;
			ro_q   <= ro;
			imm_q  <= imm;
			sub_q  <= sub;
			tgt_q  <= tgt;
			list_q <= list;
			item_q <= head.item_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign mnemonic       = mn_q;
	assign recognized     = (mn_q != thd_pkg::MN_NONE);
	assign branch_cond    = cond_q;
	assign reg_dest       = rd_q;
	assign reg_base       = rb_q;
	assign reg_offset     = ro_q;
	assign imm_value      = imm_q;
	assign sp_subtract    = sub_q;
	assign target_address = tgt_q;
	assign reg_list       = list_q;
	assign item_address   = item_q;

endmodule

### hdl/thumb_instruction_decoder.sv
// top level: thumb halfword decoder with decoupled front, queue and back
//
//   channel   direction  handshake            payload
//   config    in         cfg_wr_en            cfg_wr_data (start address)
//   input     in         in_valid / in_stall  halfword_in
//   output    out        out_valid/out_stall  mnemonic .. item_address
//
// one halfword per cycle sustained while in_stall stays low; a decoded beat is written
// into the queue by the front, then decoded by the back into the output register
// the first half of a bl yields no output beat; the pair leaves with the second half
// in_stall rises only when the two-entry queue is full, so either side may stall alone
// reset clears the address to zero, the pending bl and all valid state; no clearing pass
// a config write reloads the current address and drops any pending bl half
`timescale 1ns / 1ps

module thumb_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// halfword stream
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] halfword_in,
	// decoded instructions
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  mnemonic,
	output logic        recognized,
	output logic [3:0]  branch_cond,
	output logic [3:0]  reg_dest,
	output logic [3:0]  reg_base,
	output logic [2:0]  reg_offset,
	output logic [9:0]  imm_value,
	output logic        sp_subtract,
	output logic [31:0] target_address,
	output logic [8:0]  reg_list,
	output logic [31:0] item_address
);

	thd_pkg::q_push_t   q_push;
	thd_pkg::q_status_t q_status;
	thd_pkg::q_entry_t  q_head;
	logic               q_pop;

	// front: address tracking and bl pairing, pushes one entry per instruction
	thd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.halfword_in (halfword_in),
		.q_status    (q_status),
		.q_push      (q_push)
	);

	// decoupling queue
	thd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.pop      (q_pop),
		.q_status (q_status),
		.head     (q_head)
	);

	// back: field decode, target add and output register
	thd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.head           (q_head),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mnemonic       (mnemonic),
		.recognized     (recognized),
		.branch_cond    (branch_cond),
		.reg_dest       (reg_dest),
		.reg_base       (reg_base),
		.reg_offset     (reg_offset),
		.imm_value      (imm_value),
		.sp_subtract    (sp_subtract),
		.target_address (target_address),
		.reg_list       (reg_list),
		.item_address   (item_address)
	);

endmodule

### hdl/thd_checker.sv
// checker: port-level properties of the thumb decoder, bound to the top level
`timescale 1ns / 1ps

module thd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  mnemonic,
	input logic        recognized,
	input logic [3:0]  branch_cond,
	input logic [31:0] target_address,
	input logic [8:0]  reg_list,
	input logic [31:0] item_address
);

	// a stalled beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(item_address) && $stable(mnemonic))
		else $error("stalled output beat changed");

	a_recog: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> recognized == (mnemonic != thd_pkg::MN_NONE))
		else $error("recognized flag disagrees with mnemonic");

	a_unrec_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !recognized |->
			target_address == '0 && reg_list == '0 && branch_cond == thd_pkg::COND_AL)
		else $error("unrecognized beat carries live fields");

	a_cond_only_bcc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mnemonic != thd_pkg::MN_B_COND |-> branch_cond == thd_pkg::COND_AL)
		else $error("condition set on a non-conditional beat");

	a_lit_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mnemonic == thd_pkg::MN_LDR_LIT |-> target_address[1:0] == 2'b00)
		else $error("literal address not word aligned");

endmodule

bind thumb_instruction_decoder thd_checker u_thd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.mnemonic       (mnemonic),
	.recognized     (recognized),
	.branch_cond    (branch_cond),
	.target_address (target_address),
	.reg_list       (reg_list),
	.item_address   (item_address)
);
